FILE: rtl/core/lpm_pkg.sv
// Package for the longest prefix match route table: sizes, item codes,
// the in/out item structs, the token passed along the cell chain, popcount.
// No dependencies.
package lpm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ENTRY_IDX_W   = 4;
  localparam int CMP_W         = (IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 8;
  localparam int COST_W        = 16;
  localparam int LEN_W         = 6;
  // Ingress register, one stage per cell, result register.
  localparam int LATENCY       = TABLE_ENTRIES + 2;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   entry_valid;
    logic [ADDR_W-1:0]      network_addr;
    logic [ADDR_W-1:0]      net_mask;
    logic [ADDR_W-1:0]      gateway_addr;
    logic [PORT_W-1:0]      port_number;
    logic [COST_W-1:0]      route_cost;
    logic [ADDR_W-1:0]      dest_addr;
  } lpm_in_t;

  typedef struct packed {
    logic                   hit;
    logic [ENTRY_IDX_W-1:0] match_index;
    logic [LEN_W-1:0]       prefix_length;
    logic [ADDR_W-1:0]      next_hop_addr;
    logic [PORT_W-1:0]      out_port;
    logic [COST_W-1:0]      out_cost;
  } lpm_out_t;

  // One item in flight through the chain. Write fields are used by the
  // addressed cell; best_* fields collect the winner of a lookup.
  typedef struct packed {
    logic                   vld;
    logic                   lookup;
    logic [ENTRY_IDX_W-1:0] wr_index;
    logic                   wr_valid;
    logic [ADDR_W-1:0]      network;
    logic [ADDR_W-1:0]      mask;
    logic [LEN_W-1:0]       mask_len;
    logic [ADDR_W-1:0]      gateway;
    logic [PORT_W-1:0]      port;
    logic [COST_W-1:0]      cost;
    logic [ADDR_W-1:0]      dest;
    logic                   found;
    logic [IDX_W-1:0]       best_idx;
    logic [LEN_W-1:0]       best_len;
    logic [ADDR_W-1:0]      best_gw;
    logic [PORT_W-1:0]      best_port;
    logic [COST_W-1:0]      best_cost;
  } lpm_tok_t;

  // Count ones per byte, then add the four byte counts.
  function automatic logic [LEN_W-1:0] popcount32(input logic [ADDR_W-1:0] v);
    logic [3:0]       part [4];
    logic [LEN_W-1:0] sum;
    for (int b = 0; b < 4; b++) begin
      part[b] = 4'd0;
      for (int k = 0; k < 8; k++) begin
        part[b] = part[b] + {3'd0, v[8*b+k]};
      end
    end
    sum = LEN_W'(part[0]) + LEN_W'(part[1]) + LEN_W'(part[2]) + LEN_W'(part[3]);
    return sum;
  endfunction

endpackage

FILE: rtl/core/longest_prefix_match_lookup.sv
// IPv4 longest prefix match route table, top level. Depends on lpm_pkg,
// lpm_ingress and lpm_cell.
// From transfer to strobe an item passes the ingress register, the slot cell registers and the result register.
// Throughput: one item per cycle; busy stays low, set by the pipelined slot chain.
// Reset clears all slot valid bits and every in-flight item; results cannot stall.
module longest_prefix_match_lookup
  import lpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lpm_in_t  in_item,
  output logic     out_valid,
  output lpm_out_t out_result
);

  // Items travel down a row of slot cells, one cell per cycle. A write is
  // captured by the cell it addresses; a lookup picks up the best match as it
  // passes each cell. Items never overtake each other, so a lookup sees
  // exactly the writes transferred before it.
  lpm_tok_t tok [TABLE_ENTRIES+1];
  logic     accept;
  logic     out_valid_r;
  lpm_out_t out_result_r;
  lpm_out_t out_result_nxt;
  lpm_tok_t last;

  // The chain takes an item every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  lpm_ingress u_ingress (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_item),
    .tok_out (tok[0])
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (IDX_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];

  // Result stage: drive zeros on a miss, report the winner on a hit.
  always_comb begin
    out_result_nxt = '0;
    if (last.found) begin
      out_result_nxt.hit           = 1'b1;
      out_result_nxt.match_index   = ENTRY_IDX_W'(last.best_idx);
      out_result_nxt.prefix_length = last.best_len;
      out_result_nxt.next_hop_addr = last.best_gw;
      out_result_nxt.out_port      = last.best_port;
      out_result_nxt.out_cost      = last.best_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.vld && last.lookup;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Every lookup answers after the fixed latency.
  a_lookup_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.func == FUNC_LOOKUP)) |-> ##LATENCY out_valid)
    else $error("lookup produced no result at the expected cycle");

  // Writes produce no result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_item.func == FUNC_WRITE)) |-> ##LATENCY !out_valid)
    else $error("write produced a result");

  // A miss reports all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result.hit) |->
      (out_result.match_index == '0 && out_result.prefix_length == '0 &&
       out_result.next_hop_addr == '0 && out_result.out_port == '0 &&
       out_result.out_cost == '0))
    else $error("miss with nonzero fields");

  // Prefix length cannot exceed the address width.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.prefix_length <= LEN_W'(ADDR_W)))
    else $error("prefix length out of range");

endmodule

FILE: rtl/core/lpm_ingress.sv
// Ingress stage of the route table: turns a transferred item into a chain
// token and precomputes the mask popcount. Depends on lpm_pkg.
module lpm_ingress
  import lpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  lpm_in_t  item,
  output lpm_tok_t tok_out
);

  lpm_tok_t tok_r;
  lpm_tok_t tok_nxt;

  always_comb begin
    tok_nxt           = '0;
    tok_nxt.vld       = accept;
    tok_nxt.lookup    = (item.func == FUNC_LOOKUP);
    tok_nxt.wr_index  = item.entry_index;
    tok_nxt.wr_valid  = item.entry_valid;
    tok_nxt.network   = item.network_addr;
    tok_nxt.mask      = item.net_mask;
    tok_nxt.mask_len  = popcount32(item.net_mask);
    tok_nxt.gateway   = item.gateway_addr;
    tok_nxt.port      = item.port_number;
    tok_nxt.cost      = item.route_cost;
    tok_nxt.dest      = item.dest_addr;
    tok_nxt.found     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/core/lpm_cell.sv
// One route slot of the chain: holds a table entry, captures writes aimed
// at it and updates the best match of a passing lookup. Depends on lpm_pkg.
module lpm_cell
  import lpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_id,
  input  lpm_tok_t         tok_in,
  output lpm_tok_t         tok_out
);

  logic              valid_r;
  logic [ADDR_W-1:0] net_r;
  logic [ADDR_W-1:0] mask_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] gw_r;
  logic [PORT_W-1:0] port_r;
  logic [COST_W-1:0] cost_r;
  lpm_tok_t          tok_r;
  lpm_tok_t          tok_nxt;
  logic              wr_hit;
  logic              match;
  logic              take;

  always_comb begin
    wr_hit  = tok_in.vld && !tok_in.lookup &&
              (CMP_W'(tok_in.wr_index) == CMP_W'(cell_id));
    match   = valid_r && (((tok_in.dest ^ net_r) & mask_r) == '0);
    // Strictly longer only: on a tie the earlier (lower) slot keeps the win.
    take    = tok_in.vld && tok_in.lookup && match &&
              (!tok_in.found || (len_r > tok_in.best_len));
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.best_idx  = cell_id;
      tok_nxt.best_len  = len_r;
      tok_nxt.best_gw   = gw_r;
      tok_nxt.best_port = port_r;
      tok_nxt.best_cost = cost_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_hit) begin
      valid_r <= tok_in.wr_valid;
    end
  end

  // Entry payload: only loaded on a storing write; a clear leaves it alone.
  always_ff @(posedge clk) begin
    if (wr_hit && tok_in.wr_valid) begin
      net_r  <= tok_in.network;
      mask_r <= tok_in.mask;
      len_r  <= tok_in.mask_len;
      gw_r   <= tok_in.gateway;
      port_r <= tok_in.port;
      cost_r <= tok_in.cost;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for longest_prefix_match_lookup: directed and random route writes and lookups.
// Depends on lpm_pkg and the RTL top level; a scoreboard class predicts each lookup.
module tb;
  import lpm_pkg::*;

  // Shadow route table plus the queue of lookup answers still owed by the block.
  class route_scoreboard;
    bit [ADDR_W-1:0] slot_net [TABLE_ENTRIES];
    bit [ADDR_W-1:0] slot_mask [TABLE_ENTRIES];
    bit [ADDR_W-1:0] slot_gw [TABLE_ENTRIES];
    bit [PORT_W-1:0] slot_port [TABLE_ENTRIES];
    bit [COST_W-1:0] slot_cost [TABLE_ENTRIES];
    bit              slot_live [TABLE_ENTRIES];
    lpm_out_t        lookup_answers [$];
    int unsigned     errors;

    // Longest mask wins among live matching slots; strict compare keeps the lower index on a tie.
    function lpm_out_t best_route(bit [ADDR_W-1:0] dest);
      lpm_out_t r;
      bit       found;
      int       best_len;
      int       len;
      r = '0;
      found = 1'b0;
      best_len = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_live[i] && ((dest ^ slot_net[i]) & slot_mask[i]) == '0) begin
          len = $countones(slot_mask[i]);
          if (!found || len > best_len) begin
            found = 1'b1;
            best_len = len;
            r.hit = 1'b1;
            r.match_index = ENTRY_IDX_W'(i);
            r.prefix_length = LEN_W'(len);
            r.next_hop_addr = slot_gw[i];
            r.out_port = slot_port[i];
            r.out_cost = slot_cost[i];
          end
        end
      end
      return r;
    endfunction

    function void note_transfer(lpm_in_t it);
      int idx;
      idx = int'(it.entry_index);
      if (it.func == FUNC_WRITE) begin
        if (idx < TABLE_ENTRIES) begin
          slot_live[idx] = it.entry_valid;
          // A clearing write only drops the valid bit.
          if (it.entry_valid) begin
            slot_net[idx] = it.network_addr;
            slot_mask[idx] = it.net_mask;
            slot_gw[idx] = it.gateway_addr;
            slot_port[idx] = it.port_number;
            slot_cost[idx] = it.route_cost;
          end
        end
      end else begin
        lookup_answers.push_back(best_route(it.dest_addr));
      end
    endfunction

    function void compare(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(lpm_out_t got);
      lpm_out_t want;
      if (lookup_answers.size() == 0) begin
        $error("result with no lookup pending: hit=%0b match_index=%0d", got.hit,
               got.match_index);
        errors++;
        return;
      end
      want = lookup_answers.pop_front();
      compare("hit", want.hit, got.hit);
      compare("match_index", want.match_index, got.match_index);
      compare("prefix_length", want.prefix_length, got.prefix_length);
      compare("next_hop_addr", want.next_hop_addr, got.next_hop_addr);
      compare("out_port", want.out_port, got.out_port);
      compare("out_cost", want.out_cost, got.out_cost);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lpm_in_t  in_item = '0;
  logic     out_valid;
  lpm_out_t out_result;

  route_scoreboard routes = new();

  // Network prefixes shared by random writes and lookups so that lookups hit often.
  bit [ADDR_W-1:0] prefix_pool [4];

  longest_prefix_match_lookup uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #2 clk = ~clk;

  // Results cannot be held off: check every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      routes.check_result(out_result);
    end
  end

  // Present one item from the falling edge and hold it until a rising edge takes it.
  task automatic send(input lpm_in_t it);
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    routes.note_transfer(it);
  endtask

  // Drop start for one cycle; scramble the payload to show it is ignored.
  task automatic idle_cycle();
    logic [191:0] noise;
    lpm_in_t      junk;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    junk = noise[$bits(lpm_in_t)-1:0];
    @(negedge clk);
    start <= 1'b0;
    in_item <= junk;
  endtask

  task automatic write_route(input int idx, input bit live, input bit [31:0] net,
                             input bit [31:0] mask, input bit [31:0] gw,
                             input bit [7:0] port, input bit [15:0] cost);
    lpm_in_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.entry_index = ENTRY_IDX_W'(idx);
    it.entry_valid = live;
    it.network_addr = net;
    it.net_mask = mask;
    it.gateway_addr = gw;
    it.port_number = port;
    it.route_cost = cost;
    it.dest_addr = $urandom;
    send(it);
  endtask

  task automatic lookup(input bit [31:0] dest);
    lpm_in_t it;
    it = '0;
    it.func = FUNC_LOOKUP;
    it.dest_addr = dest;
    send(it);
  endtask

  // Mostly prefix-shaped writes and lookups aimed at stored networks; some pure noise.
  function automatic lpm_in_t random_item();
    logic [191:0] noise;
    lpm_in_t      it;
    int           plen;
    int           slot;
    int           pick;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = noise[$bits(lpm_in_t)-1:0];
    if ($urandom_range(0, 99) < 35) begin
      it.func = FUNC_WRITE;
      it.entry_index = ENTRY_IDX_W'($urandom_range(0, 15));
      it.entry_valid = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        plen = $urandom_range(0, 32);
        it.net_mask = 32'hFFFF_FFFF << (32 - plen);
      end else if (pick < 9) begin
        it.net_mask = $urandom;
      end else begin
        it.net_mask = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      if ($urandom_range(0, 9) < 6) begin
        it.network_addr = prefix_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(8, 31));
      end
    end else begin
      it.func = FUNC_LOOKUP;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        slot = $urandom_range(0, TABLE_ENTRIES - 1);
        it.dest_addr = (routes.slot_net[slot] & routes.slot_mask[slot]) |
                       ($urandom & ~routes.slot_mask[slot]);
        // Now and then flip a bit so the aimed slot misses.
        if ($urandom_range(0, 4) == 0) begin
          it.dest_addr[$urandom_range(0, 31)] ^= 1'b1;
        end
      end else if (pick < 9) begin
        it.dest_addr = prefix_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 31));
      end
    end
    return it;
  endfunction

  initial begin
    for (int p = 0; p < 4; p++) begin
      prefix_pool[p] = $urandom;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty table, extremes, ties, odd masks, clears.
    lookup(32'h0000_0000);
    lookup(32'hFFFF_FFFF);
    write_route(15, 1, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    write_route(0, 1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 8'd1, 16'd10);
    write_route(9, 1, 32'h0A01_0200, 32'hFFFF_FF00, 32'h0A01_02FE, 8'd9, 16'd90);
    write_route(2, 1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0001, 8'd2, 16'd20);
    write_route(7, 1, 32'hC0A8_0000, 32'hFFFF_0000, 32'hC0A8_0007, 8'd7, 16'd70);
    write_route(4, 1, 32'h0505_0505, 32'h0F0F_0F0F, 32'h0404_0404, 8'd4, 16'd40);
    write_route(12, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'd0, 16'd0);
    lookup(32'h0A01_0203);
    lookup(32'h0A7F_0000);
    lookup(32'hC0A8_1234);
    lookup(32'hFFFF_FFFF);
    lookup(32'h0102_0304);
    lookup(32'h75A5_F505);
    write_route(2, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    lookup(32'hC0A8_1234);
    write_route(15, 0, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0);
    lookup(32'h0102_0304);
    begin
      lpm_in_t noisy;
      // Lookup with every write field at all ones.
      noisy = '1;
      noisy.func = FUNC_LOOKUP;
      noisy.dest_addr = 32'h0A01_0299;
      send(noisy);
    end
    write_route(15, 1, 32'h0, 32'h0, 32'h0, 8'h0, 16'h0);
    lookup(32'h0000_0000);

    // Random part; items 150 to 270 run back to back with no gaps.
    for (int k = 0; k < 450; k++) begin
      if (k < 150 || k > 270) begin
        while ($urandom_range(0, 99) < 26) idle_cycle();
      end
      send(random_item());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain the outstanding lookups, then allow for the pipeline depth.
    while (routes.lookup_answers.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (routes.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by the timeout fails.
  initial begin
    #200000;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lpm_pkg.sv
rtl/core/lpm_ingress.sv
rtl/core/lpm_cell.sv
rtl/core/longest_prefix_match_lookup.sv
tb/sv/tb.sv
